FILE: rtl/q2e_pkg.sv
// shared types and constants of the quaternion to zxy euler angle converter
// used by every module of the block, no dependencies
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QUAT_WIDTH_DEF    = 16;

  localparam int QI         = 16;  // internal quaternion width, q1.15
  localparam int PW         = 2 * QI;
  localparam int RW         = 35;  // rotation term width
  localparam int R21W       = 32;  // clamped r21 width
  localparam int SQW        = 31;  // square root result bits
  localparam int REMW       = 62;  // square root remainder width
  localparam int OPW        = 36;  // cordic operand width
  localparam int CW         = 45;  // cordic vector width
  localparam int ZW         = 33;  // cordic angle accumulator width
  localparam int AW         = ZW - 16;
  localparam int NORM_MSB   = 40;
  localparam int SHW        = 6;
  localparam int OUT_W      = 48;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;
  localparam int YAW_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic signed [ZW-1:0] HALF_TURN  = 33'sd1179648000;
  localparam logic signed [ZW-1:0] ROUND_HALF = 33'sd32768;
  localparam logic signed [RW-1:0] Q30_ONE    = 35'sd1073741824;
  localparam logic signed [AW-1:0] LIM_HALF   = 17'sd18000;
  localparam logic signed [AW-1:0] LIM_QUART  = 17'sd9000;

  typedef struct packed {
    logic signed [RW-1:0]   r11;
    logic signed [RW-1:0]   r12;
    logic signed [RW-1:0]   r31;
    logic signed [RW-1:0]   r32;
    logic signed [R21W-1:0] r21;
    logic                   clamped;
  } rterm_t;

  // atan(2^-i) in 1/65536 of a hundredth of a degree
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 33'sd294912000;
      5'd1:  v = 33'sd174096719;
      5'd2:  v = 33'sd91987925;
      5'd3:  v = 33'sd46694507;
      5'd4:  v = 33'sd23437865;
      5'd5:  v = 33'sd11730358;
      5'd6:  v = 33'sd5866610;
      5'd7:  v = 33'sd2933484;
      5'd8:  v = 33'sd1466764;
      5'd9:  v = 33'sd733385;
      5'd10: v = 33'sd366693;
      5'd11: v = 33'sd183346;
      5'd12: v = 33'sd91673;
      5'd13: v = 33'sd45837;
      5'd14: v = 33'sd22918;
      5'd15: v = 33'sd11459;
      5'd16: v = 33'sd5730;
      5'd17: v = 33'sd2865;
      5'd18: v = 33'sd1432;
      5'd19: v = 33'sd716;
      5'd20: v = 33'sd358;
      5'd21: v = 33'sd179;
      5'd22: v = 33'sd90;
      5'd23: v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/q2e_front.sv
// front end: takes quaternion beats, forms the products and the rotation terms
// depends on q2e_pkg
module q2e_front #(
  parameter int QUAT_WIDTH = q2e_pkg::QUAT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [QUAT_WIDTH-1:0] quat_w,
  input  logic [QUAT_WIDTH-1:0] quat_x,
  input  logic [QUAT_WIDTH-1:0] quat_y,
  input  logic [QUAT_WIDTH-1:0] quat_z,
  input  logic                  full_i,
  output logic                  push_o,
  output q2e_pkg::rterm_t       rt_o
);

  localparam int QI   = q2e_pkg::QI;
  localparam int PW   = q2e_pkg::PW;
  localparam int RW   = q2e_pkg::RW;
  localparam int R21W = q2e_pkg::R21W;

  logic signed [QI-1:0] cw, cx, cy, cz;
  logic signed [QI-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [PW-1:0] p_xy_r, p_wz_r, p_ww_r, p_xx_r, p_yy_r;
  logic signed [PW-1:0] p_zz_r, p_wy_r, p_xz_r, p_yz_r, p_wx_r;
  logic                 f1_v_r, f2_v_r, adv;
  logic signed [RW-1:0] r21_raw;

  // truncate or pad to q1.15
  if (QUAT_WIDTH >= QI) begin : g_trunc
    assign cw = quat_w[QUAT_WIDTH-1 -: QI];
    assign cx = quat_x[QUAT_WIDTH-1 -: QI];
    assign cy = quat_y[QUAT_WIDTH-1 -: QI];
    assign cz = quat_z[QUAT_WIDTH-1 -: QI];
  end else begin : g_pad
    assign cw = {quat_w, {(QI-QUAT_WIDTH){1'b0}}};
    assign cx = {quat_x, {(QI-QUAT_WIDTH){1'b0}}};
    assign cy = {quat_y, {(QI-QUAT_WIDTH){1'b0}}};
    assign cz = {quat_z, {(QI-QUAT_WIDTH){1'b0}}};
  end

  assign adv      = !f2_v_r || !full_i;
  assign in_ready = adv;
  assign push_o   = f2_v_r && !full_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qw_r   <= cw;
      qx_r   <= cx;
      qy_r   <= cy;
      qz_r   <= cz;
      p_xy_r <= qx_r * qy_r;
      p_wz_r <= qw_r * qz_r;
      p_ww_r <= qw_r * qw_r;
      p_xx_r <= qx_r * qx_r;
      p_yy_r <= qy_r * qy_r;
      p_zz_r <= qz_r * qz_r;
      p_wy_r <= qw_r * qy_r;
      p_xz_r <= qx_r * qz_r;
      p_yz_r <= qy_r * qz_r;
      p_wx_r <= qw_r * qx_r;
    end
  end

  always_comb begin
    rt_o.r11 = (RW'(p_xy_r) + RW'(p_wz_r)) <<< 1;
    rt_o.r12 = RW'(p_ww_r) + RW'(p_xx_r) - RW'(p_yy_r) - RW'(p_zz_r);
    rt_o.r31 = (RW'(p_yz_r) + RW'(p_wx_r)) <<< 1;
    rt_o.r32 = RW'(p_ww_r) - RW'(p_xx_r) - RW'(p_yy_r) + RW'(p_zz_r);
    r21_raw  = (RW'(p_wy_r) - RW'(p_xz_r)) <<< 1;
    if (r21_raw > q2e_pkg::Q30_ONE) begin
      rt_o.r21     = q2e_pkg::Q30_ONE[R21W-1:0];
      rt_o.clamped = 1'b1;
    end else if (r21_raw < -q2e_pkg::Q30_ONE) begin
      rt_o.r21     = R21W'(-q2e_pkg::Q30_ONE);
      rt_o.clamped = 1'b1;
    end else begin
      rt_o.r21     = r21_raw[R21W-1:0];
      rt_o.clamped = 1'b0;
    end
  end

endmodule

FILE: rtl/q2e_fifo.sv
// short queue of rotation terms between front end and back end
// depends on q2e_pkg
module q2e_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  q2e_pkg::rterm_t din,
  output logic            full,
  input  logic            pop,
  output q2e_pkg::rterm_t dout,
  output logic            empty
);

  localparam int AW = q2e_pkg::FIFO_AW;

  q2e_pkg::rterm_t mem_r [q2e_pkg::FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     cnt_r;

  assign full  = (cnt_r == (AW+1)'(q2e_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

FILE: rtl/q2e_cordic.sv
// pipelined vectoring cordic, atan2(y, x) in hundredths of a degree
// depends on q2e_pkg
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [q2e_pkg::OPW-1:0] x_i,
  input  logic signed [q2e_pkg::OPW-1:0] y_i,
  output logic signed [q2e_pkg::AW-1:0]  ang_o
);

  localparam int OPW = q2e_pkg::OPW;
  localparam int CW  = q2e_pkg::CW;
  localparam int ZW  = q2e_pkg::ZW;
  localparam int SHW = q2e_pkg::SHW;

  logic signed [OPW-1:0] fx, fy, a_x_r, a_y_r, b_x_r, b_y_r;
  logic signed [ZW-1:0]  fz, a_z_r, b_z_r, zsum;
  logic [OPW-1:0]        ax, ay, a_big_r;
  logic                  a_zero_r, b_zero_r;
  logic [SHW-1:0]        msb, b_sh_r;

  logic signed [CW-1:0]  ix_r [STAGES+1];
  logic signed [CW-1:0]  iy_r [STAGES+1];
  logic signed [ZW-1:0]  iz_r [STAGES+1];
  logic                  izero_r [STAGES+1];

  // quadrant fix
  always_comb begin
    if (x_i < 0) begin
      fx = -x_i;
      fy = -y_i;
      fz = (y_i >= 0) ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN;
    end else begin
      fx = x_i;
      fy = y_i;
      fz = '0;
    end
    ax = fx[OPW-1] ? -fx : fx;
    ay = fy[OPW-1] ? -fy : fy;
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < OPW; i++) begin
      if (a_big_r[i]) msb = SHW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= fx;
      a_y_r    <= fy;
      a_z_r    <= fz;
      a_zero_r <= (x_i == 0) && (y_i == 0);
      a_big_r  <= (ax > ay) ? ax : ay;
      b_x_r    <= a_x_r;
      b_y_r    <= a_y_r;
      b_z_r    <= a_z_r;
      b_zero_r <= a_zero_r;
      b_sh_r   <= (msb >= SHW'(q2e_pkg::NORM_MSB)) ? '0 : SHW'(q2e_pkg::NORM_MSB) - msb;
      ix_r[0]    <= CW'(b_x_r) <<< b_sh_r;
      iy_r[0]    <= CW'(b_y_r) <<< b_sh_r;
      iz_r[0]    <= b_z_r;
      izero_r[0] <= b_zero_r;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        izero_r[i+1] <= izero_r[i];
        if (!iy_r[i][CW-1]) begin
          ix_r[i+1] <= ix_r[i] + (iy_r[i] >>> i);
          iy_r[i+1] <= iy_r[i] - (ix_r[i] >>> i);
          iz_r[i+1] <= iz_r[i] + q2e_pkg::atan_tab(5'(i));
        end else begin
          ix_r[i+1] <= ix_r[i] - (iy_r[i] >>> i);
          iy_r[i+1] <= iy_r[i] + (ix_r[i] >>> i);
          iz_r[i+1] <= iz_r[i] - q2e_pkg::atan_tab(5'(i));
        end
      end
    end
  end

  assign zsum = iz_r[STAGES] + q2e_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_o <= izero_r[STAGES] ? '0 : zsum[ZW-1:16];
    end
  end

endmodule

FILE: rtl/q2e_back.sv
// back end: cosine by square root, three cordic pipes, saturation, output register
// depends on q2e_pkg and q2e_cordic
module q2e_back #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               empty_i,
  output logic                               pop_o,
  input  q2e_pkg::rterm_t                    rt_i,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [q2e_pkg::ROLL_W-1:0]  roll,
  output logic signed [q2e_pkg::PITCH_W-1:0] pitch,
  output logic signed [q2e_pkg::YAW_W-1:0]   yaw,
  output logic                               clamped
);

  localparam int SQW  = q2e_pkg::SQW;
  localparam int REMW = q2e_pkg::REMW;
  localparam int OPW  = q2e_pkg::OPW;
  localparam int AW   = q2e_pkg::AW;
  localparam int R2W  = 2 * q2e_pkg::R21W;
  localparam int CL   = CORDIC_STAGES + 4;

  logic                  adv, b0_v_r, ov_r;
  q2e_pkg::rterm_t       b0_rt_r;
  logic signed [R2W-1:0] sq_r;

  logic [REMW-1:0]       s_rem_r  [SQW+1];
  logic [SQW-1:0]        s_root_r [SQW+1];
  q2e_pkg::rterm_t       s_rt_r   [SQW+1];
  logic                  s_v_r    [SQW+1];

  logic                  c_v_r  [CL];
  logic                  c_cl_r [CL];

  logic signed [AW-1:0]  yaw_a, pitch_a, roll_a;
  logic signed [AW-1:0]  yaw_s, pitch_s, roll_s;
  q2e_pkg::rterm_t       lt;
  logic signed [OPW-1:0] cosv;

  assign adv       = !ov_r || out_ready;
  assign pop_o     = adv && !empty_i;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      s_v_r[0] <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      b0_v_r <= !empty_i;
      s_v_r[0] <= b0_v_r;
      ov_r <= c_v_r[CL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_rt_r     <= rt_i;
      sq_r        <= $signed(rt_i.r21) * $signed(rt_i.r21);
      s_rt_r[0]   <= b0_rt_r;
      s_root_r[0] <= '0;
      s_rem_r[0]  <= (REMW'(1) << 60) - sq_r[REMW-1:0];
    end
  end

  // one result bit per stage, most significant first
  for (genvar j = 1; j <= SQW; j++) begin : g_sqrt
    localparam int K = SQW - j;
    logic [REMW-1:0] t;
    assign t = (REMW'(s_root_r[j-1]) << (K+1)) + (REMW'(1) << (2*K));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[j] <= 1'b0;
      end else if (adv) begin
        s_v_r[j] <= s_v_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        s_rt_r[j] <= s_rt_r[j-1];
        if (s_rem_r[j-1] >= t) begin
          s_rem_r[j]  <= s_rem_r[j-1] - t;
          s_root_r[j] <= s_root_r[j-1] | (SQW'(1) << K);
        end else begin
          s_rem_r[j]  <= s_rem_r[j-1];
          s_root_r[j] <= s_root_r[j-1];
        end
      end
    end
  end

  assign lt   = s_rt_r[SQW];
  assign cosv = $signed({{(OPW-SQW){1'b0}}, s_root_r[SQW]});

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(adv),
    .x_i(OPW'($signed(lt.r12))), .y_i(OPW'($signed(lt.r11))), .ang_o(yaw_a)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(adv),
    .x_i(cosv), .y_i(OPW'($signed(lt.r21))), .ang_o(pitch_a)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(adv),
    .x_i(OPW'($signed(lt.r32))), .y_i(OPW'($signed(lt.r31))), .ang_o(roll_a)
  );

  for (genvar c = 0; c < CL; c++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[c] <= 1'b0;
      end else if (adv) begin
        c_v_r[c] <= (c == 0) ? s_v_r[SQW] : c_v_r[(c == 0) ? 0 : c-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_cl_r[c] <= (c == 0) ? lt.clamped : c_cl_r[(c == 0) ? 0 : c-1];
      end
    end
  end

  always_comb begin
    yaw_s = (yaw_a > q2e_pkg::LIM_HALF) ? q2e_pkg::LIM_HALF :
            (yaw_a < -q2e_pkg::LIM_HALF) ? -q2e_pkg::LIM_HALF : yaw_a;
    roll_s = (roll_a > q2e_pkg::LIM_HALF) ? q2e_pkg::LIM_HALF :
             (roll_a < -q2e_pkg::LIM_HALF) ? -q2e_pkg::LIM_HALF : roll_a;
    pitch_s = (pitch_a > q2e_pkg::LIM_QUART) ? q2e_pkg::LIM_QUART :
              (pitch_a < -q2e_pkg::LIM_QUART) ? -q2e_pkg::LIM_QUART : pitch_a;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw     <= yaw_s[q2e_pkg::YAW_W-1:0];
      roll    <= roll_s[q2e_pkg::ROLL_W-1:0];
      pitch   <= pitch_s[q2e_pkg::PITCH_W-1:0];
      clamped <= c_cl_r[CL-1];
    end
  end

endmodule

FILE: rtl/quaternion_to_euler_zxy_unit.sv
// top level of the quaternion to zxy euler angle converter
// depends on q2e_pkg, q2e_front, q2e_fifo, q2e_back
//
// usage:
// in channel: one beat carries a quaternion w, x, y, z, each QUAT_WIDTH bits
// signed, fraction QUAT_WIDTH-1 bits. out channel: one beat per input beat
// with roll, pitch and yaw in hundredths of a degree; tuser flags that the
// pitch sine was clamped to magnitude one.
// throughput: one beat per cycle, sustained, with no stall on the out side.
// latency from input beat to output beat is set by two product stages, the
// queue, a 31-stage square root for the pitch cosine and the
// CORDIC_STAGES + 4 stages of the three parallel cordic pipes.
// a four-entry queue sits between the product front end and the back end;
// when the receiver stalls, the back end holds in place and the front end
// keeps taking beats until the queue fills, then drops in_tready.
// reset clears all valid flags and queue pointers; no beat is shown until
// fresh input arrives.
module quaternion_to_euler_zxy_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int QUAT_WIDTH    = q2e_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // quat_w, quat_x, quat_y, quat_z, zero pad to bytes
  input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // roll_cdeg, pitch_cdeg, yaw_cdeg, zero pad
  output logic [q2e_pkg::OUT_W-1:0]               out_tdata,
  // pitch_clamped
  output logic [0:0]                              out_tuser
);

  localparam int QW = QUAT_WIDTH;

  q2e_pkg::rterm_t                    f_rt, b_rt;
  logic                               push, full, pop, empty, clamped;
  logic signed [q2e_pkg::ROLL_W-1:0]  roll;
  logic signed [q2e_pkg::PITCH_W-1:0] pitch;
  logic signed [q2e_pkg::YAW_W-1:0]   yaw;

  q2e_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .quat_w(in_tdata[QW-1:0]), .quat_x(in_tdata[2*QW-1:QW]),
    .quat_y(in_tdata[3*QW-1:2*QW]), .quat_z(in_tdata[4*QW-1:3*QW]),
    .full_i(full), .push_o(push), .rt_o(f_rt)
  );

  q2e_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .din(f_rt), .full(full),
    .pop(pop), .dout(b_rt), .empty(empty)
  );

  q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .empty_i(empty), .pop_o(pop), .rt_i(b_rt),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .roll(roll), .pitch(pitch), .yaw(yaw), .clamped(clamped)
  );

  assign out_tdata = {1'b0, yaw, pitch, roll};
  assign out_tuser = clamped;

endmodule
